@@ src/rfap_pkg.sv @@
// ----------------------------------------------------------------------------
// rfap_pkg
// Shared constants, status codes and the hex-decode helper of the RFID ASCII frame parser.
// ----------------------------------------------------------------------------
package rfap_pkg;

   localparam logic [7:0] FRAME_STX  = 8'h02;
   localparam logic [7:0] FRAME_ETX  = 8'h03;
   localparam logic [3:0] FRAME_LEN  = 4'd14;
   localparam logic [3:0] DATA_CHARS = 4'd10;
   localparam logic [3:0] TAG_CHARS  = 4'd8;
   localparam logic [3:0] TAG_FIRST  = 4'd3;
   localparam logic [3:0] TAG_LAST   = 4'(TAG_FIRST + TAG_CHARS - 4'd1);
   localparam logic [3:0] CHECK_LAST = 4'(DATA_CHARS + 4'd2);
   localparam logic [3:0] ETX_SLOT   = 4'(FRAME_LEN - 4'd1);

   typedef enum logic [1:0] {
      ST_NEW_TAG = 2'd0,
      ST_DUP_TAG = 2'd1,
      ST_BAD_SUM = 2'd2,
      ST_BAD_LEN = 2'd3
   } status_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] digit;
   } hex_type;

   // non-hex characters flag bad and decode as zero
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.bad   = 1'b0;
      h.digit = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.digit = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.digit = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.digit = 4'(c - 8'h57);
      end else begin
         h.bad = 1'b1;
      end
      return h;
   endfunction

endpackage

@@ src/rfap_if.sv @@
// ----------------------------------------------------------------------------
// rfap_if
// Valid/ready channels of the RFID ASCII frame parser: byte in, result out.
// ----------------------------------------------------------------------------
interface rfap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfap_rsp_if import rfap_pkg::*; ;
   logic        valid;
   logic        ready;
   status_type  status;
   logic [31:0] tag;

   modport source (output valid, output status, output tag, input ready);
   modport sink   (input valid, input status, input tag, output ready);
endinterface

@@ src/rfid_ascii_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// rfid_ascii_frame_parser_top
// Byte-serial parser of a 14-byte STX/hex/checksum/ETX RFID reader frame.
// ----------------------------------------------------------------------------
// result path: an accepted ETX beat passes the input register, then its result is held in the result register
// throughput: one byte per cycle; the input register and the result register
//    pass one beat each cycle while the result side takes beats
// reset: synchronous, clears the frame position, parse state, last tag and
//    both valid flags
module rfid_ascii_frame_parser_top import rfap_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rfap_req_if.sink  req_ch,
   rfap_rsp_if.source rsp_ch
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic [3:0]  position_ff, position_in;
   logic [3:0]  nibble_hold_ff, nibble_hold_in;
   logic [7:0]  xor_accum_ff, xor_accum_in;
   logic [7:0]  received_check_ff, received_check_in;
   logic [31:0] tag_shift_ff, tag_shift_in;
   logic        bad_char_ff, bad_char_in;
   logic [31:0] last_tag_ff, last_tag_in;
   logic        out_valid_ff, out_valid_in;
   status_type  out_status_ff, out_status_in;
   logic [31:0] out_tag_ff, out_tag_in;

   logic        produce, out_free, s1_move;
   logic [3:0]  pos_eff, slot;
   logic [7:0]  pair;
   hex_type     hx;

   assign out_free      = !out_valid_ff || rsp_ch.ready;
   assign s1_move       = s1_valid_ff && (!produce || out_free);
   assign req_ch.ready  = !s1_valid_ff || s1_move;
   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.status = out_status_ff;
   assign rsp_ch.tag    = out_tag_ff;

   always_comb begin
      pos_eff           = (s1_byte_ff == FRAME_STX) ? 4'd0 : position_ff;
      slot              = pos_eff;
      hx                = hex_decode(s1_byte_ff);
      pair              = {nibble_hold_ff, hx.digit};
      position_in       = position_ff;
      nibble_hold_in    = nibble_hold_ff;
      xor_accum_in      = xor_accum_ff;
      received_check_in = received_check_ff;
      tag_shift_in      = tag_shift_ff;
      bad_char_in       = bad_char_ff;
      last_tag_in       = last_tag_ff;
      produce           = 1'b0;
      out_status_in     = ST_BAD_LEN;
      out_tag_in        = 32'd0;

      if (pos_eff >= FRAME_LEN) begin
         // overflow drops the byte
         position_in = 4'd0;
      end else begin
         position_in = 4'(pos_eff + 4'd1);
         if (slot == 4'd0) begin
            nibble_hold_in    = 4'd0;
            xor_accum_in      = 8'd0;
            received_check_in = 8'd0;
            tag_shift_in      = 32'd0;
            bad_char_in       = 1'b0;
         end else if (slot <= CHECK_LAST && s1_byte_ff != FRAME_ETX) begin
            if (hx.bad) begin
               bad_char_in = 1'b1;
            end
            if (slot >= TAG_FIRST && slot <= TAG_LAST) begin
               tag_shift_in = {tag_shift_ff[27:0], hx.digit};
            end
            if (slot[0]) begin
               nibble_hold_in = hx.digit;
            end else if (slot <= DATA_CHARS) begin
               xor_accum_in = xor_accum_ff ^ pair;
            end else begin
               received_check_in = pair;
            end
         end
         if (s1_byte_ff == FRAME_ETX) begin
            produce     = 1'b1;
            position_in = 4'd0;
            if (slot != ETX_SLOT) begin
               out_status_in = ST_BAD_LEN;
            end else if (bad_char_ff || xor_accum_ff != received_check_ff) begin
               out_status_in = ST_BAD_SUM;
            end else if (tag_shift_ff == last_tag_ff) begin
               out_status_in = ST_DUP_TAG;
               out_tag_in    = tag_shift_ff;
            end else begin
               out_status_in = ST_NEW_TAG;
               out_tag_in    = tag_shift_ff;
               last_tag_in   = tag_shift_ff;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = req_ch.valid && req_ch.ready ? 1'b1 : (s1_valid_ff && !s1_move);
      out_valid_in = (s1_move && produce) ? 1'b1 : (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         position_ff       <= 4'd0;
         nibble_hold_ff    <= 4'd0;
         xor_accum_ff      <= 8'd0;
         received_check_ff <= 8'd0;
         tag_shift_ff      <= 32'd0;
         bad_char_ff       <= 1'b0;
         last_tag_ff       <= 32'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (s1_move) begin
            position_ff       <= position_in;
            nibble_hold_ff    <= nibble_hold_in;
            xor_accum_ff      <= xor_accum_in;
            received_check_ff <= received_check_in;
            tag_shift_ff      <= tag_shift_in;
            bad_char_ff       <= bad_char_in;
            last_tag_ff       <= last_tag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_byte_ff <= req_ch.rx_byte;
      end
      if (s1_move && produce) begin
         out_status_ff <= out_status_in;
         out_tag_ff    <= out_tag_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      position_ff <= FRAME_LEN)
      else $error("frame position out of range");

   a_err_tag_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff == ST_BAD_SUM || out_status_ff == ST_BAD_LEN)
      |-> out_tag_ff == 32'd0)
      else $error("error result carries a tag");

   a_new_tag_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == ST_NEW_TAG |-> last_tag_ff == out_tag_ff)
      else $error("new tag not recorded as last tag");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("stalled input beat lost");

endmodule
